// ===== hw/rtl/bpss_pkg.sv =====
package bpss_pkg;

  localparam int MaxPower      = 4;
  localparam int WlBins        = 32;
  localparam int MaxFrame      = 1024;
  localparam int WlW           = 5;
  localparam int PixW          = 11;
  localparam int FrameW        = 11;
  localparam int RunW          = 24;
  localparam int AccW          = 64;
  localparam int PowW          = 3;
  localparam int NumPow        = MaxPower + 1;
  localparam int SpecDepth     = NumPow * WlBins;
  localparam int SpecAw        = $clog2(SpecDepth);
  localparam int ImgPlane      = WlBins * MaxFrame;
  localparam int ImgDepth      = NumPow * ImgPlane;
  localparam int ImgAw         = $clog2(ImgDepth);
  localparam int PlaneAw       = $clog2(ImgPlane);
  localparam logic [AccW-1:0] OneQ16 = 64'd65536;

  // configuration register indexes
  localparam logic [1:0] CfgSpecEn  = 2'd0;
  localparam logic [1:0] CfgImgEn   = 2'd1;
  localparam logic [1:0] CfgFrame   = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_ADDR,
    ST_READ_WAIT,
    ST_OUT,
    ST_UPD_START,
    ST_UPD_RD,
    ST_UPD_WAIT,
    ST_UPD_MUL,
    ST_UPD_WR
  } bpss_state_e;

  // controller to datapath
  typedef struct packed {
    logic clear_step;   // write zero at clear counter, advance
    logic take_item;    // latch the accepted request
    logic read_issue;   // issue read of the addressed statistic
    logic read_load;    // capture read data into output register
    logic run_fold;     // fold weight into runs, hold key
    logic upd_load;     // set up close of one store (spec or image)
    logic upd_issue;    // issue read of entry k
    logic upd_mul_hi;   // multiply upper half of power by run sum
    logic upd_mul;      // multiply lower half, form next power
    logic upd_write;    // write sum, advance k
    logic upd_spec;     // which store the update targets
    logic clear_runs;   // clear run_open after last item
    logic clr_spec_run;
    logic clr_img_run;
  } bpss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic is_read;
    logic last;
    logic close_spec;   // the spectrum store is enabled
    logic close_img;
    logic need_spec;    // key change closes spectrum run
    logic need_img;
    logic pow_done;     // k reached MaxPower
  } bpss_sts_t;

endpackage

// ===== hw/rtl/bpss_ram.sv =====
module bpss_ram #(
  parameter int Width = 64,
  parameter int Depth = 160
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== hw/rtl/bpss_ctrl.sv =====
module bpss_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  bpss_pkg::bpss_sts_t sts_i,
  output bpss_pkg::bpss_cmd_t cmd_o
);
  import bpss_pkg::*;

  bpss_state_e state_q, state_d;
  // phase: 0 pre-close (key change), 1 post-fold close (last item)
  logic phase_q, phase_d;
  logic spec_q, spec_d;      // current update target is spectrum store

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      phase_q <= 1'b0;
      spec_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      spec_q  <= spec_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    spec_d      = spec_q;
    cmd_o       = '0;
    cmd_o.upd_spec = spec_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          phase_d = 1'b0;
          state_d = ST_READ_ADDR;
        end
      end
      ST_READ_ADDR: begin
        if (sts_i.is_read) begin
          cmd_o.read_issue = 1'b1;
          state_d = ST_READ_WAIT;
        end else begin
          state_d = ST_UPD_START;
          spec_d  = 1'b1;
        end
      end
      ST_READ_WAIT: begin
        cmd_o.read_load = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      ST_UPD_START: begin
        // walk spectrum then image close for this phase
        priority if (spec_q && ((phase_q ? 1'b1 : sts_i.need_spec))) begin
          if (sts_i.close_spec) begin
            cmd_o.upd_load = 1'b1;
            state_d = ST_UPD_RD;
          end else begin
            cmd_o.clr_spec_run = 1'b1;
            spec_d = 1'b0;
          end
        end else if (spec_q) begin
          spec_d = 1'b0;
        end else if (phase_q ? 1'b1 : sts_i.need_img) begin
          if (sts_i.close_img) begin
            cmd_o.upd_load = 1'b1;
            state_d = ST_UPD_RD;
          end else begin
            cmd_o.clr_img_run = 1'b1;
            if (phase_q) begin
              cmd_o.clear_runs = 1'b1;
              state_d = ST_IDLE;
            end else if (sts_i.last) begin
              cmd_o.run_fold = 1'b1;
              phase_d = 1'b1;
              spec_d  = 1'b1;
            end else begin
              cmd_o.run_fold = 1'b1;
              state_d = ST_IDLE;
            end
          end
        end else begin
          if (phase_q) begin
            cmd_o.clear_runs = 1'b1;
            state_d = ST_IDLE;
          end else begin
            cmd_o.run_fold = 1'b1;
            if (sts_i.last) begin
              phase_d = 1'b1;
              spec_d  = 1'b1;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_UPD_RD: begin
        cmd_o.upd_issue = 1'b1;
        state_d = ST_UPD_WAIT;
      end
      ST_UPD_WAIT: begin
        cmd_o.upd_mul_hi = 1'b1;
        state_d = ST_UPD_MUL;
      end
      ST_UPD_MUL: begin
        cmd_o.upd_mul = 1'b1;
        state_d = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        cmd_o.upd_write = 1'b1;
        if (sts_i.pow_done) begin
          // finished this store; clear its run and go on
          state_d = ST_UPD_START;
          if (spec_q) begin
            cmd_o.clr_spec_run = 1'b1;
            spec_d = 1'b0;
          end else begin
            cmd_o.clr_img_run = 1'b1;
            // mark image handled: force skip by moving on
            if (phase_q) begin
              cmd_o.clear_runs = 1'b1;
              state_d = ST_IDLE;
            end else begin
              cmd_o.run_fold = 1'b1;
              if (sts_i.last) begin
                phase_d = 1'b1;
                spec_d  = 1'b1;
              end else begin
                state_d = ST_IDLE;
              end
            end
          end
        end else begin
          state_d = ST_UPD_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/bpss_dp.sv =====
module bpss_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [bpss_pkg::FrameW-1:0]   cfg_data_i,
  input  logic                          kind_i,
  input  logic [15:0]                   weight_i,
  input  logic [bpss_pkg::WlW-1:0]      wavelength_bin_i,
  input  logic signed [bpss_pkg::PixW-1:0] pixel_bin_i,
  input  logic                          last_item_i,
  input  logic                          store_select_i,
  input  logic [bpss_pkg::PowW-1:0]     power_select_i,
  output logic [bpss_pkg::AccW-1:0]     read_value_o,
  input  bpss_pkg::bpss_cmd_t           cmd_i,
  output bpss_pkg::bpss_sts_t           sts_o
);
  import bpss_pkg::*;

  // configuration
  logic              spec_en_q, img_en_q;
  logic [FrameW-1:0] frame_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spec_en_q <= 1'b0;
      img_en_q  <= 1'b0;
      frame_q   <= FrameW'(MaxFrame);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgSpecEn: spec_en_q <= cfg_data_i[0];
        CfgImgEn:  img_en_q  <= cfg_data_i[0];
        CfgFrame:  frame_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [FrameW-1:0] eff_frame;
  always_comb begin
    eff_frame = frame_q;
    if (frame_q == '0) eff_frame = FrameW'(1);
    if (frame_q > FrameW'(MaxFrame)) eff_frame = FrameW'(MaxFrame);
  end

  // latched request
  logic              kind_q, last_q, sel_q;
  logic [15:0]       wt_q;
  logic [WlW-1:0]    wl_q;
  logic [PixW-1:0]   pix_q;
  logic [PowW-1:0]   pw_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      kind_q <= kind_i;
      last_q <= last_item_i;
      sel_q  <= store_select_i;
      wt_q   <= weight_i;
      wl_q   <= wavelength_bin_i;
      pix_q  <= pixel_bin_i;
      pw_q   <= power_select_i;
    end
  end

  // run state; a run cleared in the folding cycle starts from zero
  logic [RunW-1:0] srun_q, irun_q;
  logic [WlW-1:0]  hwl_q;
  logic [PixW-1:0] hpix_q;
  logic            open_q;
  logic [RunW-1:0] s_base, i_base;
  logic [RunW:0]   s_sum, i_sum;
  assign s_base = cmd_i.clr_spec_run ? '0 : srun_q;
  assign i_base = cmd_i.clr_img_run ? '0 : irun_q;
  assign s_sum = {1'b0, s_base} + {{(RunW-15){1'b0}}, wt_q};
  assign i_sum = {1'b0, i_base} + {{(RunW-15){1'b0}}, wt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srun_q <= '0;
      irun_q <= '0;
      hwl_q  <= '0;
      hpix_q <= '0;
      open_q <= 1'b0;
    end else if (cmd_i.run_fold) begin
      srun_q <= s_sum[RunW] ? '1 : s_sum[RunW-1:0];
      irun_q <= i_sum[RunW] ? '1 : i_sum[RunW-1:0];
      hwl_q  <= wl_q;
      hpix_q <= pix_q;
      open_q <= 1'b1;
    end else begin
      if (cmd_i.clr_spec_run) srun_q <= '0;
      if (cmd_i.clr_img_run)  irun_q <= '0;
      if (cmd_i.clear_runs) open_q <= 1'b0;
    end
  end

  // image address of held key and of read key
  logic [PlaneAw-1:0] hold_img_a, rd_img_a;
  logic               hold_img_ok, rd_img_ok;
  logic [PlaneAw-1:0] hold_mul, rd_mul;
  assign hold_mul   = PlaneAw'(hwl_q) * PlaneAw'(eff_frame);
  assign rd_mul     = PlaneAw'(wl_q) * PlaneAw'(eff_frame);
  assign hold_img_a = hold_mul + PlaneAw'(hpix_q);
  assign rd_img_a   = rd_mul + PlaneAw'(pix_q);
  assign hold_img_ok = !hpix_q[PixW-1] && (hpix_q < eff_frame);
  assign rd_img_ok   = !pix_q[PixW-1] && (pix_q < eff_frame);

  // clear sweep counter shared by both stores
  logic [ImgAw-1:0] clr_q;
  logic             clr_done;
  assign clr_done = (clr_q == ImgAw'(ImgDepth - 1));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clear_step && !clr_done) clr_q <= clr_q + 1'b1;
  end

  // update engine
  logic [PowW-1:0]  k_q;
  logic [AccW-1:0]  pow_q;
  logic [RunW-1:0]  w_q;
  logic [AccW-1:0]  acc_q;
  logic [AccW-1:0]  spec_rd, img_rd;
  logic [AccW+RunW-1:0] prod;
  logic [AccW:0]    sum;
  logic [AccW-1:0]  next_pow_q;
  logic [31:0]      mul_a;
  logic [RunW+31:0] mul_p;
  logic [RunW+31:0] prod_hi_q;

  // one 32 x 24 multiplier, upper half of the power first, then lower half
  assign mul_a = cmd_i.upd_mul ? pow_q[31:0] : pow_q[AccW-1:32];
  assign mul_p = {{RunW{1'b0}}, mul_a} * {32'd0, w_q};
  assign prod  = {prod_hi_q, 32'd0} + {32'd0, mul_p};
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_load) begin
      k_q   <= '0;
      pow_q <= OneQ16;
      w_q   <= cmd_i.upd_spec ? srun_q : irun_q;
    end
    if (cmd_i.upd_mul_hi) begin
      prod_hi_q <= mul_p;
    end
    if (cmd_i.upd_mul) begin
      acc_q      <= cmd_i.upd_spec ? spec_rd : img_rd;
      next_pow_q <= (prod[AccW+RunW-1:AccW] != '0) ? '1 : prod[AccW+15:16];
    end
    if (cmd_i.upd_write) begin
      k_q   <= k_q + 1'b1;
      pow_q <= next_pow_q;
    end
  end
  assign sum = {1'b0, acc_q} + {1'b0, pow_q};

  // store ports
  logic             s_we, i_we;
  logic [SpecAw-1:0] s_a;
  logic [ImgAw-1:0]  i_a;
  logic [AccW-1:0]   s_wd, i_wd, wdata;
  assign wdata = sum[AccW] ? '1 : sum[AccW-1:0];
  always_comb begin
    s_we = 1'b0;
    i_we = 1'b0;
    s_wd = wdata;
    i_wd = wdata;
    s_a  = SpecAw'(k_q * WlBins + hwl_q);
    i_a  = ImgAw'(k_q * ImgPlane + hold_img_a);
    if (cmd_i.clear_step) begin
      s_we = (clr_q < ImgAw'(SpecDepth));
      i_we = 1'b1;
      s_wd = '0;
      i_wd = '0;
      s_a  = clr_q[SpecAw-1:0];
      i_a  = clr_q;
    end else if (cmd_i.read_issue) begin
      s_a = SpecAw'(pw_q * WlBins + wl_q);
      i_a = ImgAw'(pw_q * ImgPlane + rd_img_a);
    end else if (cmd_i.upd_write) begin
      s_we = cmd_i.upd_spec;
      i_we = !cmd_i.upd_spec;
    end
  end

  bpss_ram #(.Width(AccW), .Depth(SpecDepth)) u_spec (
    .clk_i, .we_i(s_we), .addr_i(s_a), .wdata_i(s_wd), .rdata_o(spec_rd));
  bpss_ram #(.Width(AccW), .Depth(ImgDepth)) u_img (
    .clk_i, .we_i(i_we), .addr_i(i_a), .wdata_i(i_wd), .rdata_o(img_rd));

  // read result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.read_load) begin
      if (pw_q > PowW'(MaxPower)) read_value_o <= '0;
      else if (!sel_q) read_value_o <= spec_rd;
      else if (rd_img_ok) read_value_o <= img_rd;
      else read_value_o <= '0;
    end
  end

  // status
  assign sts_o.clear_done = clr_done;
  assign sts_o.is_read    = kind_q;
  assign sts_o.last       = last_q;
  assign sts_o.need_spec  = open_q && (hwl_q != wl_q);
  assign sts_o.need_img   = open_q && ((hwl_q != wl_q) || (hpix_q != pix_q));
  assign sts_o.close_spec = spec_en_q;
  assign sts_o.close_img  = img_en_q && hold_img_ok;
  assign sts_o.pow_done   = (k_q == PowW'(MaxPower));

endmodule

// ===== hw/rtl/binned_power_sum_statistics_unit.sv =====
// channel   direction  handshake              payload
// in        input      in_valid_i/in_ready_o  kind, weight, wavelength_bin, pixel_bin,
//                                             last_item, store_select, power_select
// out       output     out_valid_o/out_ready_i read_value
// cfg       input      cfg_we_i               cfg_index_i, cfg_data_i
//
// a request is taken only after the previous one is done and any result is taken;
// a contribution adds a read-modify-write of each of 5 powers for each store a
// closing run updates, through the single port, and a last item adds a second
// closing pass plus its updates. after reset a clearing pass sweeps both stores
// over all 163840 image addresses; no request is taken meanwhile. a result waits
// in its register until taken.
module binned_power_sum_statistics_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [bpss_pkg::FrameW-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            kind_i,
  input  logic [15:0]                     weight_i,
  input  logic [bpss_pkg::WlW-1:0]        wavelength_bin_i,
  input  logic signed [bpss_pkg::PixW-1:0] pixel_bin_i,
  input  logic                            last_item_i,
  input  logic                            store_select_i,
  input  logic [bpss_pkg::PowW-1:0]       power_select_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bpss_pkg::AccW-1:0]       read_value_o
);
  import bpss_pkg::*;

  bpss_cmd_t cmd;
  bpss_sts_t sts;

  bpss_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd));

  bpss_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .kind_i, .weight_i, .wavelength_bin_i, .pixel_bin_i, .last_item_i,
    .store_select_i, .power_select_i, .read_value_o,
    .cmd_i(cmd), .sts_o(sts));

endmodule

// ===== hw/rtl/bpss_checker.sv =====
module bpss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] read_value_o
);

  // one request at a time: never ready while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready with pending result");

  // a result is held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o))
    else $error("result dropped or changed");

  // a taken result is not repeated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o) else $error("result repeated");

  // an accepted request does not show ready in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready after accept");

endmodule

bind binned_power_sum_statistics_unit bpss_checker u_bpss_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bpss_pkg::*;

  localparam int unsigned CycleLimit = 4000000;
  localparam int DirRows = 19;
  localparam int Drain = 120;
  localparam logic [10:0] PixNeg = 11'h7ff;

  typedef struct {
    bit        kind;
    bit [15:0] weight;
    bit [4:0]  wl;
    bit [10:0] pix;
    bit        last;
    bit        sel;
    bit [2:0]  pw;
  } req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [FrameW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic kind_i = 1'b0;
  logic [15:0] weight_i = '0;
  logic [WlW-1:0] wavelength_bin_i = '0;
  logic signed [PixW-1:0] pixel_bin_i = '0;
  logic last_item_i = 1'b0;
  logic store_select_i = 1'b0;
  logic [PowW-1:0] power_select_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [AccW-1:0] read_value_o;

  binned_power_sum_statistics_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  bit              spec_en, img_en;
  bit [10:0]       frame_cfg;
  bit [23:0]       spec_run, img_run;
  bit [4:0]        held_wl;
  bit [10:0]       held_pix;
  bit              run_open;
  logic [63:0]     spec_acc [SpecDepth];
  logic [63:0]     img_acc [int];

  logic [63:0] read_value_q [$];
  int unsigned err_cnt = 0;
  int unsigned cyc = 0;
  bit quiet = 1'b0;

  function automatic int unsigned eff_frame();
    int unsigned f;
    f = frame_cfg;
    if (f == 0) f = 1;
    if (f > MaxFrame) f = MaxFrame;
    return f;
  endfunction

  function automatic bit img_index(bit [4:0] wl, bit [10:0] pix, output int addr);
    int unsigned f;
    f = eff_frame();
    addr = 0;
    if (pix[10] || pix >= f) return 1'b0;
    addr = pix + wl * f;
    return 1'b1;
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = a + b;
    return s[64] ? '1 : s[63:0];
  endfunction

  // add w^0..w^4 of a closed run into one bin
  function automatic void add_powers(bit to_img, int base, bit [23:0] w);
    logic [63:0] p;
    logic [127:0] prod;
    int idx;
    p = OneQ16;
    for (int k = 0; k <= MaxPower; k++) begin
      if (to_img) begin
        idx = base + k * ImgPlane;
        img_acc[idx] = sat_add(img_acc.exists(idx) ? img_acc[idx] : 64'd0, p);
      end else begin
        spec_acc[base + k * WlBins] = sat_add(spec_acc[base + k * WlBins], p);
      end
      prod = {64'd0, p} * w;
      p = (prod[127:64] != 0) ? '1 : prod[79:16];
    end
  endfunction

  function automatic void close_spec();
    if (spec_en) add_powers(1'b0, held_wl, spec_run);
    spec_run = '0;
  endfunction

  function automatic void close_img();
    int a;
    if (img_en && img_index(held_wl, held_pix, a)) add_powers(1'b1, a, img_run);
    img_run = '0;
  endfunction

  function automatic bit [23:0] run_add(bit [23:0] s, bit [15:0] w);
    bit [24:0] t;
    t = s + w;
    return (t > 25'hffffff) ? 24'hffffff : t[23:0];
  endfunction

  // advance the statistics predictor by one request; returns 1 with a read value
  function automatic bit stats_step(req_t r, output logic [63:0] val);
    int a;
    val = '0;
    if (r.kind) begin
      if (r.pw <= MaxPower) begin
        if (!r.sel) val = spec_acc[r.pw * WlBins + r.wl];
        else if (img_index(r.wl, r.pix, a)) begin
          a = a + r.pw * ImgPlane;
          val = img_acc.exists(a) ? img_acc[a] : 64'd0;
        end
      end
      return 1'b1;
    end
    if (run_open) begin
      if (held_wl != r.wl) begin
        close_spec();
        close_img();
      end else if (held_pix != r.pix) begin
        close_img();
      end
    end
    spec_run = run_add(spec_run, r.weight);
    img_run = run_add(img_run, r.weight);
    held_wl = r.wl;
    held_pix = r.pix;
    run_open = 1'b1;
    if (r.last) begin
      close_spec();
      close_img();
      run_open = 1'b0;
    end
    return 1'b0;
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [FrameW-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CfgSpecEn) spec_en = data[0];
    else if (idx == CfgImgEn) img_en = data[0];
    else if (idx == CfgFrame) frame_cfg = data;
  endtask

  // drive one request and wait for it to be taken
  task automatic send_req(req_t r, bit typed, logic [63:0] typed_val);
    logic [63:0] v;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    if (!quiet && $urandom_range(99) < 7) repeat ($urandom_range(1, 4)) @(negedge clk_i);
    in_valid_i = 1'b1;
    kind_i = r.kind;
    weight_i = r.weight;
    wavelength_bin_i = r.wl;
    pixel_bin_i = r.pix;
    last_item_i = r.last;
    store_select_i = r.sel;
    power_select_i = r.pw;
    do @(posedge clk_i); while (!in_ready_o);
    if (stats_step(r, v)) read_value_q.insert(read_value_q.size(), typed ? typed_val : v);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (read_value_q.size() == 0);
    repeat (Drain) @(negedge clk_i);
  endtask

  function automatic req_t rq(bit kind, bit [15:0] w, bit [4:0] wl, bit [10:0] pix,
                              bit last, bit sel, bit [2:0] pw);
    req_t r;
    r.kind = kind; r.weight = w; r.wl = wl; r.pix = pix;
    r.last = last; r.sel = sel; r.pw = pw;
    return r;
  endfunction

  function automatic req_t rand_read(bit [4:0] wl, bit [10:0] pix);
    return rq(1'b1, $urandom, wl, pix, $urandom, $urandom,
              ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
  endfunction

  // random pixel: mostly inside the frame, sometimes negative or past it
  function automatic bit [10:0] rand_pix();
    int unsigned f, c;
    f = eff_frame();
    c = $urandom_range(19);
    if (c == 0) return PixNeg;
    if (c == 1) return 11'h400 | $urandom_range(0, 1023);
    if (c == 2) return $urandom_range(0, 1023);
    return $urandom_range(0, f - 1);
  endfunction

  // one sorted contribution list with reads mixed in
  task automatic send_list(ref int sent);
    bit [4:0] wl;
    bit [10:0] pix;
    int nkeys, reps;
    bit heavy;
    nkeys = $urandom_range(1, 8);
    wl = $urandom_range(0, 31);
    for (int k = 0; k < nkeys; k++) begin
      if ($urandom_range(2) == 0) wl = $urandom_range(0, 31);
      pix = rand_pix();
      heavy = ($urandom_range(150) == 0);
      reps = heavy ? 260 : $urandom_range(1, 4);
      for (int i = 0; i < reps; i++) begin
        send_req(rq(1'b0, heavy ? 16'hffff : 16'($urandom), wl, pix,
                    (k == nkeys - 1) && (i == reps - 1), $urandom, $urandom), 0, '0);
        sent++;
        if ($urandom_range(6) == 0) begin
          send_req(rand_read(wl, pix), 0, '0);
          sent++;
        end
        if ($urandom_range(19) == 0) begin
          send_req(rand_read($urandom, $urandom), 0, '0);
          sent++;
        end
      end
    end
    // read back what the list touched
    repeat ($urandom_range(2, 6)) begin
      send_req(rand_read(wl, ($urandom_range(1) == 0) ? pix : rand_pix()), 0, '0);
      sent++;
    end
  endtask

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (read_value_q.size() == 0) begin
        $error("read_value: unexpected result, actual %h", read_value_o);
        err_cnt++;
      end else begin
        if (read_value_o !== read_value_q[0]) begin
          $error("read_value: expected %h actual %h", read_value_q[0], read_value_o);
          err_cnt++;
        end
        void'(read_value_q.pop_front());
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= quiet ? 1'b1 : ($urandom_range(99) >= 7);
  end

  // run limit
  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    req_t dir_tab [DirRows];
    bit dir_typed [DirRows];
    logic [63:0] dir_val [DirRows];
    bit [10:0] frames [8];
    int sent;

    spec_en = 0; img_en = 0; frame_cfg = 11'd1024;
    spec_run = 0; img_run = 0; held_wl = 0; held_pix = 0; run_open = 0;
    foreach (spec_acc[i]) spec_acc[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows; typed values where obvious
    foreach (dir_typed[i]) begin
      dir_typed[i] = 0;
      dir_val[i] = '0;
    end
    dir_tab[0]  = rq(1, 0, 0, 0, 0, 0, 0);                 dir_typed[0] = 1;
    dir_tab[1]  = rq(1, 0, 31, 3, 0, 1, 4);                dir_typed[1] = 1;
    dir_tab[2]  = rq(1, 0, 0, 0, 1, 0, 7);                 dir_typed[2] = 1;
    dir_tab[3]  = rq(0, 16'hffff, 0, 0, 0, 0, 0);
    dir_tab[4]  = rq(0, 16'hffff, 0, 0, 0, 1, 7);
    dir_tab[5]  = rq(0, 1, 0, 1, 0, 0, 0);
    dir_tab[6]  = rq(0, 0, 1, PixNeg, 0, 0, 0);
    dir_tab[7]  = rq(0, 16'h8000, 31, 1023, 1, 0, 0);
    dir_tab[8]  = rq(1, 0, 0, 0, 0, 0, 0);                 dir_typed[8] = 1;
    dir_val[8] = OneQ16;
    dir_tab[9]  = rq(1, 0, 0, 0, 0, 0, 1);
    dir_tab[10] = rq(1, 0, 0, 0, 0, 0, 4);
    dir_tab[11] = rq(1, 0, 0, 0, 0, 1, 2);
    dir_tab[12] = rq(1, 0, 0, 1, 0, 1, 0);                 dir_typed[12] = 1;
    dir_val[12] = OneQ16;
    dir_tab[13] = rq(1, 0, 1, PixNeg, 0, 1, 0);            dir_typed[13] = 1;
    dir_tab[14] = rq(1, 0, 31, 0, 0, 0, 0);                dir_typed[14] = 1;
    dir_val[14] = OneQ16;
    dir_tab[15] = rq(1, 0, 31, 1023, 0, 1, 0);             dir_typed[15] = 1;
    dir_tab[16] = rq(1, 0, 0, 0, 0, 1, 5);                 dir_typed[16] = 1;
    dir_tab[17] = rq(0, 100, 5, 2, 1, 0, 0);
    dir_tab[18] = rq(1, 0, 5, 2, 0, 1, 1);

    cfg_write(CfgSpecEn, 1);
    cfg_write(CfgImgEn, 1);
    cfg_write(CfgFrame, 4);
    for (int i = 0; i < DirRows; i++) send_req(dir_tab[i], dir_typed[i], dir_val[i]);
    settle();

    // random phases over several settings
    frames = '{11'd4, 11'd1024, 11'd0, 11'd2047, 11'd1, 11'd7, 11'd16, 11'd1024};
    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(CfgSpecEn, (ph == 2 || ph == 5) ? 0 : 1);
      cfg_write(CfgImgEn, (ph == 1 || ph == 5) ? 0 : 1);
      cfg_write(CfgFrame, frames[ph]);
      quiet = (ph == 2);
      sent = 0;
      while (sent < 210) send_list(sent);
      quiet = 1'b0;
      settle();
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
